### hdl/sfp_pkg.sv
// ----------------------------------------------------------------------------
// sfp_pkg
// Shared codes, constants and types of the sync framed packet parser.
// ----------------------------------------------------------------------------
`default_nettype none

package sfp_pkg;

    // Frame sync pattern and type limit
    localparam logic [7:0]  SYNC_FIRST  = 8'hAA;
    localparam logic [7:0]  SYNC_SECOND = 8'h55;
    localparam logic [15:0] SYNC_SUM    = 16'h00FF;
    localparam logic [7:0]  TYPE_LIMIT  = 8'd3;

    // Parser phases
    localparam logic [2:0] PH_SYNC = 3'd0;
    localparam logic [2:0] PH_TYPE = 3'd1;
    localparam logic [2:0] PH_LEN  = 3'd2;
    localparam logic [2:0] PH_DATA = 3'd3;
    localparam logic [2:0] PH_CSUM = 3'd4;

    // Status codes
    localparam logic [2:0] ST_BUSY     = 3'd0;
    localparam logic [2:0] ST_OK       = 3'd1;
    localparam logic [2:0] ST_SYNC_ERR = 3'd2;
    localparam logic [2:0] ST_TYPE_ERR = 3'd3;
    localparam logic [2:0] ST_CSUM_ERR = 3'd4;

    typedef struct packed {
        logic [2:0] status;
        logic       payload_valid;
        logic [7:0] payload_byte;
        logic [1:0] message_type;
    } t_result;

endpackage

`default_nettype wire

### hdl/sfp_core.sv
// ----------------------------------------------------------------------------
// sfp_core
// Parser state and the per-byte step: one byte in, one result out.
// ----------------------------------------------------------------------------
`default_nettype none

module sfp_core
    import sfp_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_step,
    input  wire logic [7:0] i_byte,
    output t_result         o_result
);

    logic [2:0]  r_phase, n_phase;
    logic        r_flag, n_flag;
    logic [7:0]  r_first, n_first;
    logic [1:0]  r_type, n_type;
    logic [15:0] r_len, n_len;
    logic [15:0] r_count, n_count;
    logic [15:0] r_sum, n_sum;
    logic [7:0]  r_csum_low, n_csum_low;

    logic [15:0] sum_add;
    logic [15:0] len_full;
    logic [15:0] cnt_inc;
    logic [15:0] csum_got;
    logic [15:0] csum_want;
    t_result     res;

    assign sum_add   = r_sum + {8'd0, i_byte};
    assign len_full  = {i_byte, r_len[7:0]};
    assign cnt_inc   = r_count + 16'd1;
    assign csum_got  = {i_byte, r_csum_low};
    assign csum_want = 16'd0 - r_sum;

    always_comb begin
        n_phase    = r_phase;
        n_flag     = r_flag;
        n_first    = r_first;
        n_type     = r_type;
        n_len      = r_len;
        n_count    = r_count;
        n_sum      = r_sum;
        n_csum_low = r_csum_low;
        res        = '{status: ST_BUSY, payload_valid: 1'b0,
                       payload_byte: 8'd0, message_type: 2'd0};

        unique case (r_phase)
            PH_SYNC: begin
                if (!r_flag) begin
                    n_first = i_byte;
                    n_flag  = 1'b1;
                end else begin
                    n_flag = 1'b0;
                    if (r_first != SYNC_FIRST || i_byte != SYNC_SECOND) begin
                        res.status = ST_SYNC_ERR;
                        n_phase    = PH_SYNC;
                        n_sum      = 16'd0;
                        n_count    = 16'd0;
                    end else begin
                        n_sum   = SYNC_SUM;
                        n_phase = PH_TYPE;
                    end
                end
            end
            PH_TYPE: begin
                if (i_byte >= TYPE_LIMIT) begin
                    res.status = ST_TYPE_ERR;
                    n_phase    = PH_SYNC;
                    n_flag     = 1'b0;
                    n_sum      = 16'd0;
                    n_count    = 16'd0;
                end else begin
                    n_type           = i_byte[1:0];
                    n_sum            = sum_add;
                    res.message_type = i_byte[1:0];
                    n_phase          = PH_LEN;
                    n_flag           = 1'b0;
                end
            end
            PH_LEN: begin
                res.message_type = r_type;
                n_sum            = sum_add;
                if (!r_flag) begin
                    n_len  = {r_len[15:8], i_byte};
                    n_flag = 1'b1;
                end else begin
                    n_len   = len_full;
                    n_flag  = 1'b0;
                    n_count = 16'd0;
                    // skip straight to the checksum on an empty payload
                    n_phase = (len_full != 16'd0) ? PH_DATA : PH_CSUM;
                end
            end
            PH_DATA: begin
                res.message_type  = r_type;
                res.payload_valid = 1'b1;
                res.payload_byte  = i_byte;
                n_sum             = sum_add;
                n_count           = cnt_inc;
                if (cnt_inc >= r_len) begin
                    n_phase = PH_CSUM;
                    n_flag  = 1'b0;
                end
            end
            PH_CSUM: begin
                res.message_type = r_type;
                if (!r_flag) begin
                    n_csum_low = i_byte;
                    n_flag     = 1'b1;
                end else begin
                    res.status = (csum_got == csum_want) ? ST_OK : ST_CSUM_ERR;
                    n_phase    = PH_SYNC;
                    n_flag     = 1'b0;
                    n_sum      = 16'd0;
                    n_count    = 16'd0;
                end
            end
            default: begin
                // unused phase: resync and take this byte as the first sync byte
                n_phase = PH_SYNC;
                n_first = i_byte;
                n_flag  = 1'b1;
                n_sum   = 16'd0;
                n_count = 16'd0;
            end
        endcase
    end

    assign o_result = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_SYNC;
            r_flag     <= 1'b0;
            r_first    <= 8'd0;
            r_type     <= 2'd0;
            r_len      <= 16'd0;
            r_count    <= 16'd0;
            r_sum      <= 16'd0;
            r_csum_low <= 8'd0;
        end else if (i_step) begin
            r_phase    <= n_phase;
            r_flag     <= n_flag;
            r_first    <= n_first;
            r_type     <= n_type;
            r_len      <= n_len;
            r_count    <= n_count;
            r_sum      <= n_sum;
            r_csum_low <= n_csum_low;
        end
    end

    // Any final status sends the parser back to a clean hunt
    a_final_rehunt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && res.status != ST_BUSY
        |=> r_phase == PH_SYNC && !r_flag && r_sum == 16'd0 && r_count == 16'd0)
        else $error("parser not back in hunt after final status");

    // A good sync pair moves to the type byte with the sync bytes summed
    a_sync_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && r_phase == PH_SYNC && r_flag && res.status == ST_BUSY
        |=> r_phase == PH_TYPE && r_sum == SYNC_SUM)
        else $error("sync pair accepted without entering type phase");

    // Payload phase is only ever entered with a nonzero length
    a_data_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_DATA |-> r_len != 16'd0)
        else $error("payload phase with zero length");

    // Idle cycles leave the parser state untouched
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_step |=> $stable(r_phase) && $stable(r_sum) && $stable(r_count))
        else $error("parser state moved without a byte");

endmodule

`default_nettype wire

### hdl/sync_framed_packet_parser_top.sv
// ----------------------------------------------------------------------------
// sync_framed_packet_parser_top
// Byte-stream frame parser: sync, type, length, payload, additive checksum.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: i_valid / o_stall with one received byte on i_rx_byte.
//   Output channel: o_valid / i_stall with one result per byte: o_status,
//   o_payload_valid, o_payload_byte, o_message_type.
//   A byte is held in an input register, parsed by the core and written to the
//   output register, from which its result is shown and can transfer out.
//   The block takes one byte every cycle while the receiver does not stall
//   the output; the parse step (state update plus 16-bit adds) sets that figure.
//   A stall from the receiver holds the output register; the input register
//   keeps taking bytes as long as it drains into the output register, and
//   o_stall rises only when both registers are full and the output is held.
//   Synchronous active-low reset empties both registers and puts the parser
//   into sync hunting with all framing state cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module sync_framed_packet_parser_top
    import sfp_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [7:0] i_rx_byte,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic [2:0]      o_status,
    output logic            o_payload_valid,
    output logic [7:0]      o_payload_byte,
    output logic [1:0]      o_message_type
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    t_result    r_out;
    t_result    core_res;
    logic       out_adv;
    logic       step;

    assign out_adv = !r_out_valid || !i_stall;
    assign step    = r_in_valid && out_adv;
    assign o_stall = r_in_valid && !out_adv;

    sfp_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_byte   (r_in_byte),
        .o_result (core_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (!o_stall) begin
                r_in_valid <= i_valid;
            end
            if (out_adv) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    // Payload registers: capture on transfer, hold otherwise
    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in_byte <= i_rx_byte;
        end
        if (step) begin
            r_out <= core_res;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_status        = r_out.status;
    assign o_payload_valid = r_out.payload_valid;
    assign o_payload_byte  = r_out.payload_byte;
    assign o_message_type  = r_out.message_type;

endmodule

`default_nettype wire

### tb/sv/sync_framed_packet_parser_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sync_framed_packet_parser_top_tb
// Self-checking bench for the byte-stream frame parser.
// Feeds directed frames and random traffic (good frames, bad checksums, sync
// and type errors, noise) through the valid/stall channels with varying
// gaps and back-pressure. Each byte's status, payload and type are predicted
// from a local copy of the framing state and compared against every result.
// ----------------------------------------------------------------------------

module sync_framed_packet_parser_top_tb
    import sfp_pkg::*;
;

    localparam int QUIET_LIMIT = 2000;
    localparam int HOLD_CYCLES = 40;

    // Tracks the framing state and queues the result expected for each byte.
    class frame_scoreboard;
        t_result    pending_results[$];
        logic [2:0] phase;
        bit         second_half;
        logic [7:0] sync_lo;
        logic [1:0] frame_kind;
        logic [15:0] frame_len;
        logic [15:0] data_count;
        logic [15:0] sum;
        logic [7:0] csum_lo;
        int errors;
        int checked;
        int n_ok;
        int n_csum_err;
        int n_sync_err;
        int n_type_err;
        int n_payload;

        function new();
            phase      = PH_SYNC;
            second_half = 1'b0;
            sync_lo    = '0;
            frame_kind = '0;
            frame_len  = '0;
            data_count = '0;
            sum        = '0;
            csum_lo    = '0;
        endfunction

        function void restart_hunt();
            phase       = PH_SYNC;
            second_half = 1'b0;
            sum         = '0;
            data_count  = '0;
        endfunction

        function void note_byte(input logic [7:0] b);
            t_result    r;
            logic [15:0] want;
            r = '0;
            case (phase)
                PH_SYNC: begin
                    if (!second_half) begin
                        sync_lo     = b;
                        second_half = 1'b1;
                    end else begin
                        second_half = 1'b0;
                        if (sync_lo != SYNC_FIRST || b != SYNC_SECOND) begin
                            r.status = ST_SYNC_ERR;
                            restart_hunt();
                        end else begin
                            sum   = SYNC_SUM;
                            phase = PH_TYPE;
                        end
                    end
                end
                PH_TYPE: begin
                    if (b >= TYPE_LIMIT) begin
                        r.status = ST_TYPE_ERR;
                        restart_hunt();
                    end else begin
                        frame_kind     = b[1:0];
                        sum            = sum + b;
                        r.message_type = frame_kind;
                        phase          = PH_LEN;
                        second_half    = 1'b0;
                    end
                end
                PH_LEN: begin
                    r.message_type = frame_kind;
                    sum = sum + b;
                    if (!second_half) begin
                        frame_len[7:0] = b;
                        second_half    = 1'b1;
                    end else begin
                        frame_len[15:8] = b;
                        second_half     = 1'b0;
                        data_count      = '0;
                        phase = (frame_len != 16'd0) ? PH_DATA : PH_CSUM;
                    end
                end
                PH_DATA: begin
                    r.message_type  = frame_kind;
                    r.payload_valid = 1'b1;
                    r.payload_byte  = b;
                    sum        = sum + b;
                    data_count = data_count + 16'd1;
                    n_payload++;
                    if (data_count >= frame_len) begin
                        phase       = PH_CSUM;
                        second_half = 1'b0;
                    end
                end
                default: begin
                    r.message_type = frame_kind;
                    if (!second_half) begin
                        csum_lo     = b;
                        second_half = 1'b1;
                    end else begin
                        want     = 16'd0 - sum;
                        r.status = ({b, csum_lo} == want) ? ST_OK : ST_CSUM_ERR;
                        restart_hunt();
                    end
                end
            endcase
            case (r.status)
                ST_OK:       n_ok++;
                ST_CSUM_ERR: n_csum_err++;
                ST_SYNC_ERR: n_sync_err++;
                ST_TYPE_ERR: n_type_err++;
                default: ;
            endcase
            pending_results.push_back(r);
        endfunction

        function void check_result(input logic [2:0] st, input logic pv,
                                   input logic [7:0] pb, input logic [1:0] mt);
            t_result e;
            if (pending_results.size() == 0) begin
                $display("%0t: result with nothing expected (status %0d)", $time, st);
                errors++;
                return;
            end
            e = pending_results.pop_front();
            checked++;
            if (st !== e.status) begin
                $display("%0t: status expected %0d got %0d", $time, e.status, st);
                errors++;
            end
            if (pv !== e.payload_valid) begin
                $display("%0t: payload_valid expected %0d got %0d",
                         $time, e.payload_valid, pv);
                errors++;
            end
            if (pb !== e.payload_byte) begin
                $display("%0t: payload_byte expected %02h got %02h",
                         $time, e.payload_byte, pb);
                errors++;
            end
            if (mt !== e.message_type) begin
                $display("%0t: message_type expected %0d got %0d",
                         $time, e.message_type, mt);
                errors++;
            end
        endfunction
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic [7:0] i_rx_byte = 8'h00;
    logic       i_stall = 1'b0;
    logic       o_stall;
    logic       o_valid;
    logic [2:0] o_status;
    logic       o_payload_valid;
    logic [7:0] o_payload_byte;
    logic [1:0] o_message_type;

    frame_scoreboard sb;
    int items_sent = 0;
    int idle_pct = 0;
    int stall_pct = 0;
    int hold_asks = 0;
    int hold_done = 0;
    int hold_left = 0;
    int quiet_cycles = 0;

    sync_framed_packet_parser_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_rx_byte       (i_rx_byte),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_status        (o_status),
        .o_payload_valid (o_payload_valid),
        .o_payload_byte  (o_payload_byte),
        .o_message_type  (o_message_type)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Receiver: check each output transfer, then pick the next stall.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall)
                sb.check_result(o_status, o_payload_valid, o_payload_byte, o_message_type);
            if (hold_done != hold_asks) begin
                hold_done = hold_asks;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge i_clk);
        $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
        $display("simulation failed");
        $finish;
    end

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_rx_byte <= b;
        do @(posedge i_clk); while (o_stall);
        sb.note_byte(b);
        items_sent++;
    endtask

    // fill < 0 gives random payload bytes; bad_csum flips one checksum bit.
    task automatic send_frame(input logic [7:0] kind, input int len, input int fill,
                              input bit bad_csum);
        logic [15:0] total;
        logic [15:0] csum;
        logic [15:0] len16;
        logic [7:0]  b;
        len16 = len[15:0];
        total = SYNC_SUM + kind + len16[7:0] + len16[15:8];
        send_byte(SYNC_FIRST);
        send_byte(SYNC_SECOND);
        send_byte(kind);
        send_byte(len16[7:0]);
        send_byte(len16[15:8]);
        for (int k = 0; k < len; k++) begin
            b = (fill < 0) ? 8'($urandom_range(255)) : 8'(fill);
            total = total + b;
            send_byte(b);
        end
        csum = 16'd0 - total;
        if (bad_csum)
            csum = csum ^ (16'd1 << $urandom_range(15));
        send_byte(csum[7:0]);
        send_byte(csum[15:8]);
    endtask

    // Stop offering and wait until every expected result has been seen.
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_results.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic random_traffic(input int count);
        int target;
        int pick;
        int len;
        logic [7:0] a;
        logic [7:0] b;
        target = items_sent + count;
        while (items_sent < target) begin
            pick = $urandom_range(99);
            if (pick < 65) begin
                len = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(6);
                send_frame(8'($urandom_range(2)), len, -1, $urandom_range(4) == 0);
            end else if (pick < 75) begin
                send_byte(SYNC_FIRST);
                send_byte(SYNC_SECOND);
                send_byte(8'($urandom_range(255, 3)));
            end else if (pick < 85) begin
                // correct first sync byte, wrong second
                b = 8'($urandom_range(255));
                if (b == SYNC_SECOND)
                    b = ~b;
                send_byte(SYNC_FIRST);
                send_byte(b);
            end else begin
                // noise in whole pairs so the sync search stays aligned
                repeat ($urandom_range(3, 1)) begin
                    a = 8'($urandom_range(255));
                    b = 8'($urandom_range(255));
                    if (a == SYNC_FIRST && b == SYNC_SECOND)
                        b = ~b;
                    send_byte(a);
                    send_byte(b);
                end
            end
        end
    endtask

    initial begin
        sb = new();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: zero length, max type with 0xFF payload, bad checksum,
        // sync mismatch, rejected type
        send_frame(8'd0, 0, 0, 1'b0);
        send_frame(8'd2, 1, 8'hFF, 1'b0);
        send_frame(8'd1, 0, 0, 1'b1);
        send_byte(SYNC_FIRST);
        send_byte(8'h54);
        send_byte(SYNC_FIRST);
        send_byte(SYNC_SECOND);
        send_byte(TYPE_LIMIT);
        drain();

        for (int mode = 0; mode < 4; mode++) begin
            case (mode)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 53; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 53; end
                default: begin idle_pct = 35; stall_pct = 35; end
            endcase
            if (mode == 0) begin
                // long payload: high length byte set and the sum wraps
                send_frame(8'd2, 16'h0100, 8'hFF, 1'b0);
            end
            if (mode == 2) begin
                // long receiver hold while bytes keep coming
                hold_asks++;
                idle_pct = 0;
                send_frame(8'd1, 24, -1, 1'b0);
            end
            random_traffic(70);
            drain();
        end

        repeat (8) @(posedge i_clk);
        $display("%0d bytes sent, %0d results checked, %0d payload bytes",
                 items_sent, sb.checked, sb.n_payload);
        $display("frames ok %0d, checksum errors %0d, sync errors %0d, type errors %0d",
                 sb.n_ok, sb.n_csum_err, sb.n_sync_err, sb.n_type_err);
        if (sb.errors == 0 && sb.pending_results.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
